[src/lnef_pkg.sv]
// Package for the line numbering and escape filter.
// Holds the register codes, the character constants and the run descriptor
// type shared by the front, the descriptor queue and the back. No dependencies.
package lnef_pkg;

   // Configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 1;

   localparam logic [CSR_INDEX_W-1:0] CSR_NUMBER_LINES         = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NUMBER_NONBLANK_ONLY = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHOW_LINE_ENDS       = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SQUEEZE_BLANK_LINES  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHOW_TABS            = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHOW_NONPRINTING     = 3'd5;

   typedef struct packed {
      logic number_lines;
      logic number_nonblank_only;
      logic show_line_ends;
      logic squeeze_blank_lines;
      logic show_tabs;
      logic show_nonprinting;
   } csr_type;

   // Run layout: optional number prefix (six digits and a tab), then a body
   localparam int DIGITS     = 6;
   localparam int PREFIX_LEN = DIGITS + 1;
   localparam int BODY_MAX   = 4;

   typedef logic [DIGITS-1:0][3:0] bcd_type;   // element 0 is the least significant digit

   localparam bcd_type BCD_ONE = 24'h000001;

   typedef struct packed {
      logic                       has_number;
      bcd_type                    number_bcd;
      logic [2:0]                 body_len;    // 1 to BODY_MAX
      logic [BODY_MAX-1:0][7:0]   body;        // element 0 goes out first
   } run_desc_type;

   // Characters
   localparam logic [7:0] CHAR_TAB      = 8'h09;
   localparam logic [7:0] CHAR_NEWLINE  = 8'h0A;
   localparam logic [7:0] CHAR_SPACE    = 8'h20;
   localparam logic [7:0] CHAR_DOLLAR   = 8'h24;
   localparam logic [7:0] CHAR_DASH     = 8'h2D;
   localparam logic [7:0] CHAR_ZERO     = 8'h30;
   localparam logic [7:0] CHAR_QUESTION = 8'h3F;
   localparam logic [7:0] CHAR_M        = 8'h4D;
   localparam logic [7:0] CHAR_CARET    = 8'h5E;
   localparam logic [7:0] CHAR_DEL      = 8'h7F;
   localparam logic [7:0] CTRL_LIMIT    = 8'h20;
   localparam logic [7:0] CTRL_OFFSET   = 8'h40;

endpackage

[src/lnef_front.sv]
// Front of the line numbering and escape filter: takes one byte a cycle
// while the queue is not full, tracks line state and the BCD line counter,
// and builds a run descriptor. Depends on lnef_pkg.
module lnef_front (
   input  logic                  clock,
   input  logic                  reset,
   input  lnef_pkg::csr_type     csr,
   input  logic                  push,
   input  logic [7:0]            req_in_byte,
   input  logic                  queue_full,
   output logic                  full,
   output logic                  desc_push,
   output lnef_pkg::run_desc_type desc
);
   import lnef_pkg::*;

   logic    inside_line_ff, inside_line_in;
   logic    after_blank_ff, after_blank_in;
   bcd_type line_bcd_ff, line_bcd_in;
   bcd_type bcd_inc;
   logic    carry;

   logic       accept;
   logic       is_newline;
   logic       drop;
   logic       escape;
   logic [7:0] low;
   logic [7:0] tail0, tail1;
   logic [2:0] tail_len;

   assign full       = queue_full;
   assign accept     = push && !queue_full;
   assign is_newline = (req_in_byte == CHAR_NEWLINE);
   assign drop       = is_newline && !inside_line_ff && csr.squeeze_blank_lines
                       && after_blank_ff;
   assign desc_push  = accept && !drop;

   // Saturating BCD increment; a carry out of the top digit means 999999
   always_comb begin
      bcd_inc = line_bcd_ff;
      carry   = 1'b1;
      for (int i = 0; i < DIGITS; i++) begin
         if (carry) begin
            if (line_bcd_ff[i] == 4'd9) begin
               bcd_inc[i] = 4'd0;
            end else begin
               bcd_inc[i] = line_bcd_ff[i] + 4'd1;
               carry      = 1'b0;
            end
         end
      end
   end

   // Escape tail for the low seven bits
   assign escape = csr.show_nonprinting && !(req_in_byte == CHAR_TAB && !csr.show_tabs);
   assign low    = {1'b0, req_in_byte[6:0]};

   always_comb begin
      if (low < CTRL_LIMIT) begin
         tail0    = CHAR_CARET;
         tail1    = low + CTRL_OFFSET;
         tail_len = 3'd2;
      end else if (low == CHAR_DEL) begin
         tail0    = CHAR_CARET;
         tail1    = CHAR_QUESTION;
         tail_len = 3'd2;
      end else begin
         tail0    = low;
         tail1    = low;
         tail_len = 3'd1;
      end
   end

   // Descriptor
   always_comb begin
      desc.number_bcd = line_bcd_ff;
      desc.body       = '{default: CHAR_NEWLINE};
      if (is_newline) begin
         desc.has_number = csr.number_lines && !csr.number_nonblank_only && !inside_line_ff;
         if (csr.show_line_ends) begin
            desc.body[0]  = CHAR_DOLLAR;
            desc.body[1]  = CHAR_NEWLINE;
            desc.body_len = 3'd2;
         end else begin
            desc.body[0]  = CHAR_NEWLINE;
            desc.body_len = 3'd1;
         end
      end else begin
         desc.has_number = csr.number_lines && !inside_line_ff;
         if (escape && req_in_byte[7]) begin
            desc.body[0]  = CHAR_M;
            desc.body[1]  = CHAR_DASH;
            desc.body[2]  = tail0;
            desc.body[3]  = tail1;
            desc.body_len = tail_len + 3'd2;
         end else if (escape) begin
            desc.body[0]  = tail0;
            desc.body[1]  = tail1;
            desc.body_len = tail_len;
         end else begin
            desc.body[0]  = req_in_byte;
            desc.body_len = 3'd1;
         end
      end
   end

   // Line state
   always_comb begin
      inside_line_in = inside_line_ff;
      after_blank_in = after_blank_ff;
      line_bcd_in    = line_bcd_ff;
      if (desc_push) begin
         if (is_newline) begin
            if (!inside_line_ff) after_blank_in = 1'b1;
            inside_line_in = 1'b0;
         end else begin
            inside_line_in = 1'b1;
            after_blank_in = 1'b0;
         end
         if (desc.has_number && !carry) line_bcd_in = bcd_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_line_ff <= 1'b0;
         after_blank_ff <= 1'b0;
         line_bcd_ff    <= BCD_ONE;
      end else begin
         inside_line_ff <= inside_line_in;
         after_blank_ff <= after_blank_in;
         line_bcd_ff    <= line_bcd_in;
      end
   end

endmodule

[src/lnef_queue.sv]
// Descriptor queue between the front and the back of the filter.
// Plain register FIFO with a fill count. Depends on lnef_pkg.
module lnef_queue #(
   parameter int DEPTH = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  lnef_pkg::run_desc_type push_desc,
   input  logic                   pop,
   output lnef_pkg::run_desc_type head_desc,
   output logic                   full,
   output logic                   empty
);
   import lnef_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   run_desc_type     entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == FULL_CNT);
   assign empty     = (count_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign head_desc = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (do_push) entries_ff[wr_ptr_ff] <= push_desc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[src/lnef_back.sv]
// Back of the filter: walks the head descriptor one word a cycle while the
// output register is free or being drained, and holds the current word there. Depends on lnef_pkg.
module lnef_back (
   input  logic                   clock,
   input  logic                   reset,
   input  lnef_pkg::run_desc_type head_desc,
   input  logic                   head_valid,
   output logic                   head_pop,
   input  logic                   pop,
   output logic                   empty,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_last_of_run
);
   import lnef_pkg::*;

   logic [3:0] run_index_ff, run_index_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff;
   logic       rsp_last_ff;

   logic [3:0] prefix;
   logic [3:0] run_len;
   logic [3:0] body_pos;
   logic       is_last;
   logic       load;
   logic [7:0] cur_byte;
   logic [7:0] digit_char [DIGITS];
   logic       zero_so_far;

   assign prefix   = head_desc.has_number ? 4'(PREFIX_LEN) : 4'd0;
   assign run_len  = prefix + {1'b0, head_desc.body_len};
   assign body_pos = run_index_ff - prefix;
   assign is_last  = (run_index_ff == run_len - 4'd1);

   // Digits most significant first; blank leading zeros, keep the last digit
   always_comb begin
      zero_so_far = 1'b1;
      for (int p = 0; p < DIGITS; p++) begin
         zero_so_far = zero_so_far && (head_desc.number_bcd[DIGITS-1-p] == 4'd0);
         if (zero_so_far && p != DIGITS - 1) begin
            digit_char[p] = CHAR_SPACE;
         end else begin
            digit_char[p] = CHAR_ZERO + {4'd0, head_desc.number_bcd[DIGITS-1-p]};
         end
      end
   end

   always_comb begin
      if (head_desc.has_number && run_index_ff < 4'(DIGITS)) begin
         cur_byte = digit_char[run_index_ff[2:0]];
      end else if (head_desc.has_number && run_index_ff == 4'(DIGITS)) begin
         cur_byte = CHAR_TAB;
      end else begin
         cur_byte = head_desc.body[body_pos[1:0]];
      end
   end

   // Load the output register whenever it is free or being drained
   assign load     = head_valid && (!rsp_valid_ff || pop);
   assign head_pop = load && is_last;

   always_comb begin
      run_index_in = run_index_ff;
      if (load) run_index_in = is_last ? 4'd0 : run_index_ff + 4'd1;
      rsp_valid_in = load || (rsp_valid_ff && !pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_index_ff <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         run_index_ff <= run_index_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_byte_ff <= cur_byte;
         rsp_last_ff <= is_last;
      end
   end

   assign empty           = !rsp_valid_ff;
   assign rsp_out_byte    = rsp_byte_ff;
   assign rsp_last_of_run = rsp_last_ff;

endmodule

[src/text_line_number_escape_filter_unit.sv]
// Top level of the line numbering and escape filter.
// Instantiates lnef_front, lnef_queue and lnef_back; depends on lnef_pkg.
//
// Text filter in the manner of cat -n/-b/-E/-s/-T/-v. Each input word is one
// byte of text; it turns into a run of zero to eleven output words, the last
// of which carries rsp_last_of_run. The front takes a byte every cycle while
// full is low, updates line state and the saturating BCD line counter
// (999999 repeats once reached) and writes a run descriptor into a queue of
// QUEUE_DEPTH entries; a squeezed blank line writes nothing. The back walks
// the oldest descriptor into a single output register, one output word per
// cycle while that register is free or being popped; a plain text byte gives
// one word, a numbered, escaped high control byte up to eleven. The output
// register sets the output pace; the queue absorbs bursts so input and
// output stall independently. A word reaches the output through the queue
// entry and then the output register. Registers are written through
// csr_write_enable, csr_index and csr_data (bit 0); the user must write them
// only while the block is idle, which the block itself does not enforce;
// indexes past the last register are ignored. Reset is synchronous and clears
// the control state, the registers to zero and the line counter to one.
module text_line_number_escape_filter_unit #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   // input channel
   input  logic                            push,
   output logic                            full,
   input  logic [7:0]                      req_in_byte,
   // result channel
   output logic                            empty,
   input  logic                            pop,
   output logic [7:0]                      rsp_out_byte,
   output logic                            rsp_last_of_run,
   // configuration
   input  logic                            csr_write_enable,
   input  logic [lnef_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lnef_pkg::CSR_DATA_W-1:0]  csr_data
);
   import lnef_pkg::*;

   csr_type      csr_ff, csr_in;
   logic         desc_push;
   run_desc_type front_desc;
   run_desc_type head_desc;
   logic         queue_full, queue_empty;
   logic         head_pop;

   // Register writes: decode the index, drop writes past the last register
   always_comb begin
      csr_in = csr_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_NUMBER_LINES:         csr_in.number_lines         = csr_data[0];
            CSR_NUMBER_NONBLANK_ONLY: csr_in.number_nonblank_only = csr_data[0];
            CSR_SHOW_LINE_ENDS:       csr_in.show_line_ends       = csr_data[0];
            CSR_SQUEEZE_BLANK_LINES:  csr_in.squeeze_blank_lines  = csr_data[0];
            CSR_SHOW_TABS:            csr_in.show_tabs            = csr_data[0];
            CSR_SHOW_NONPRINTING:     csr_in.show_nonprinting     = csr_data[0];
            default:                  csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= '0;
      end else begin
         csr_ff <= csr_in;
      end
   end

   // Classify each byte and build its run descriptor
   lnef_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr         (csr_ff),
      .push        (push),
      .req_in_byte (req_in_byte),
      .queue_full  (queue_full),
      .full        (full),
      .desc_push   (desc_push),
      .desc        (front_desc)
   );

   // Hold descriptors until the back gets to them
   lnef_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (desc_push),
      .push_desc (front_desc),
      .pop       (head_pop),
      .head_desc (head_desc),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   // Expand the oldest descriptor into output words
   lnef_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_desc       (head_desc),
      .head_valid      (!queue_empty),
      .head_pop        (head_pop),
      .pop             (pop),
      .empty           (empty),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

   // Reset leaves both sides drained
   a_reset_drained: assert property (@(posedge clock)
      reset |=> (empty && !full))
      else $error("block not drained after reset");

   // A descriptor written into the queue is still waiting there next cycle
   a_push_lands: assert property (@(posedge clock) disable iff (reset)
      desc_push |=> !queue_empty)
      else $error("pushed descriptor lost from the queue");

   // With nothing queued, nothing held and nothing arriving, no word appears
   a_no_invented_word: assert property (@(posedge clock) disable iff (reset)
      (queue_empty && empty && !desc_push) |=> empty)
      else $error("output word appeared without a descriptor");

endmodule

[bench/tb_text_line_number_escape_filter_unit.sv]
// Self-checking bench for text_line_number_escape_filter_unit: directed table, then random text.
// Expected output words come from a predictor of the filter kept in this file.
// Depends on lnef_pkg and the RTL under src only.
`timescale 1ns / 100ps

module tb_text_line_number_escape_filter_unit;
   import lnef_pkg::*;

   // Run limits and idling
   localparam int          CYCLE_LIMIT   = 200000;
   localparam int          MAX_GAP       = 13;
   localparam int          DRAIN_CYCLES  = 12;   // covers a squeezed newline still in flight
   localparam int          HOLD_CYCLES   = 150;  // long receiver hold-off for the pressure phase
   localparam int          RANDOM_PHASES = 6;
   localparam int          PHASE_BYTES   = 31;
   localparam int          PRINT_CAP     = 40;
   localparam int unsigned LINE_LIMIT    = 999999;

   // Register indexes past the last register; writes there must be ignored
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HI = 3'd7;

   // Settings: bit i drives the register with index i
   localparam logic [5:0] SET_PLAIN = 6'd0;
   localparam logic [5:0] SET_ALL   = 6'h3F;
   localparam logic [5:0] SET_NUMBER_ESCAPE_ENDS =
      (6'd1 << CSR_NUMBER_LINES) | (6'd1 << CSR_SHOW_LINE_ENDS) |
      (6'd1 << CSR_SHOW_NONPRINTING);
   localparam logic [5:0] SET_ORPHAN_MODES =
      (6'd1 << CSR_NUMBER_NONBLANK_ONLY) | (6'd1 << CSR_SHOW_TABS);

   typedef logic [7:0] byte_queue_type[$];

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
   } word_type;

   typedef struct {
      bit         new_setting;
      logic [5:0] setting;
      logic [7:0] in_byte;
      bit         typed;
      string      run_text;
   } stimulus_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   push = 1'b0;
   logic                   full;
   logic [7:0]             req_in_byte = 8'h00;
   logic                   empty;
   logic                   pop = 1'b0;
   logic [7:0]             rsp_out_byte;
   logic                   rsp_last_of_run;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   // Predictor state: a copy of the registers and the line state
   csr_type     filter_cfg;
   logic        in_line;
   logic        after_empty_line;
   logic [19:0] line_no;

   word_type         expected_words[$];
   stimulus_row_type directed_rows[$];

   bit reset_done = 0;
   bit no_idle    = 0;   // both sides run without gaps
   bit rush       = 0;   // sender runs without gaps
   bit hold_request = 0; // receiver takes one long hold-off

   int cycle_count    = 0;
   int mismatches     = 0;
   int words_checked  = 0;
   int bytes_sent     = 0;
   int settings_used  = 0;
   int input_stalls   = 0;

   text_line_number_escape_filter_unit uut (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_in_byte      (req_in_byte),
      .empty            (empty),
      .pop              (pop),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_last_of_run  (rsp_last_of_run),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Watchdog: a hung handshake ends the run here
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words still expected", cycle_count,
                  expected_words.size());
         $display("tb_text_line_number_escape_filter_unit failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= PRINT_CAP)
         $display("[%0d] word %0d: %s", cycle_count, words_checked, what);
   endtask

   // Six digits, right aligned and space padded, then a tab; advance the
   // counter, holding it once it reaches the limit.
   function automatic logic [PREFIX_LEN-1:0][7:0] next_line_prefix();
      logic [PREFIX_LEN-1:0][7:0] p;
      int unsigned                v;
      v = (line_no > LINE_LIMIT) ? LINE_LIMIT : line_no;
      for (int i = DIGITS - 1; i >= 0; i--) begin
         if (v != 0 || i == DIGITS - 1) begin
            p[i] = CHAR_ZERO + 8'(v % 10);
         end else begin
            p[i] = CHAR_SPACE;
         end
         v = v / 10;
      end
      p[DIGITS] = CHAR_TAB;
      if (line_no < LINE_LIMIT) begin
         line_no = line_no + 20'd1;
      end else begin
         line_no = 20'(LINE_LIMIT);
      end
      return p;
   endfunction

   // Predict the output run of one text byte and update the line state
   function automatic void filter_byte(input logic [7:0] b, output byte_queue_type run);
      logic [PREFIX_LEN-1:0][7:0] p;
      logic [7:0]                 c;
      bit                         squeezed;
      run = {};
      squeezed = 0;
      if (b == CHAR_NEWLINE) begin
         if (!in_line) begin
            if (filter_cfg.squeeze_blank_lines && after_empty_line) squeezed = 1;
            after_empty_line = 1'b1;
         end
         if (!squeezed) begin
            if (filter_cfg.number_lines && !filter_cfg.number_nonblank_only && !in_line) begin
               p = next_line_prefix();
               for (int i = 0; i < PREFIX_LEN; i++) run.push_back(p[i]);
            end
            if (filter_cfg.show_line_ends) run.push_back(CHAR_DOLLAR);
            run.push_back(CHAR_NEWLINE);
            in_line = 1'b0;
         end
      end else begin
         if (filter_cfg.number_lines && !in_line) begin
            p = next_line_prefix();
            for (int i = 0; i < PREFIX_LEN; i++) run.push_back(p[i]);
         end
         in_line = 1'b1;
         c = b;
         if (filter_cfg.show_nonprinting && !(c == CHAR_TAB && !filter_cfg.show_tabs)) begin
            if (c[7]) begin
               run.push_back(CHAR_M);
               run.push_back(CHAR_DASH);
               c[7] = 1'b0;
            end
            if (c < CTRL_LIMIT) begin
               run.push_back(CHAR_CARET);
               run.push_back(c + CTRL_OFFSET);
            end else if (c == CHAR_DEL) begin
               run.push_back(CHAR_CARET);
               run.push_back(CHAR_QUESTION);
            end else begin
               run.push_back(c);
            end
         end else begin
            run.push_back(c);
         end
         after_empty_line = 1'b0;
      end
   endfunction

   // Mostly short lines of mixed text, with empty lines, tabs, control,
   // DEL and high bytes sprinkled in
   function automatic logic [7:0] random_text_byte();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 25) return CHAR_NEWLINE;
      if (pick < 60) return 8'($urandom_range(32, 126));
      if (pick < 68) return CHAR_TAB;
      if (pick < 78) return 8'($urandom_range(0, 31));
      if (pick < 82) return ($urandom_range(0, 1) != 0) ? CHAR_DEL : 8'hFF;
      return 8'($urandom_range(128, 255));
   endfunction

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx, input logic v);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_data         <= v;
      @(posedge clock);
      case (idx)
         CSR_NUMBER_LINES:         filter_cfg.number_lines = v;
         CSR_NUMBER_NONBLANK_ONLY: filter_cfg.number_nonblank_only = v;
         CSR_SHOW_LINE_ENDS:       filter_cfg.show_line_ends = v;
         CSR_SQUEEZE_BLANK_LINES:  filter_cfg.squeeze_blank_lines = v;
         CSR_SHOW_TABS:            filter_cfg.show_tabs = v;
         CSR_SHOW_NONPRINTING:     filter_cfg.show_nonprinting = v;
         default: ;
      endcase
   endtask

   // Drop push, wait for every expected word and a little slack, then write
   // all registers plus the two spare indexes, which must not alias.
   task automatic apply_setting(input logic [5:0] s);
      push <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      write_register(CSR_NUMBER_LINES,         s[CSR_NUMBER_LINES]);
      write_register(CSR_NUMBER_NONBLANK_ONLY, s[CSR_NUMBER_NONBLANK_ONLY]);
      write_register(CSR_SHOW_LINE_ENDS,       s[CSR_SHOW_LINE_ENDS]);
      write_register(CSR_SQUEEZE_BLANK_LINES,  s[CSR_SQUEEZE_BLANK_LINES]);
      write_register(CSR_SHOW_TABS,            s[CSR_SHOW_TABS]);
      write_register(CSR_SHOW_NONPRINTING,     s[CSR_SHOW_NONPRINTING]);
      write_register(CSR_SPARE_LO,             1'b1);
      write_register(CSR_SPARE_HI,             1'b1);
      csr_write_enable <= 1'b0;
      settings_used++;
   endtask

   // Offer one byte after a random gap; keep push high across back-to-back
   // words so it never drops and rises within one step. On acceptance, queue
   // the typed run if the row has one, else the predicted run.
   task automatic send_byte(input logic [7:0] b, input bit typed, input string run_text);
      int             gap;
      byte_queue_type run;
      gap = (no_idle || rush) ? 0 : $urandom_range(0, MAX_GAP);
      if (gap != 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push        <= 1'b1;
      req_in_byte <= b;
      do begin
         @(posedge clock);
         if (full) input_stalls++;
      end while (full);
      filter_byte(b, run);
      if (typed) begin
         run = {};
         for (int i = 0; i < run_text.len(); i++) run.push_back(run_text[i]);
      end
      for (int i = 0; i < run.size(); i++)
         expected_words.push_back('{out_byte: run[i], last_of_run: (i == run.size() - 1)});
      bytes_sent++;
   endtask

   task automatic add_setting_row(input logic [5:0] s);
      directed_rows.push_back('{new_setting: 1, setting: s, in_byte: 8'h00, typed: 0,
                                run_text: ""});
   endtask

   task automatic add_byte_row(input logic [7:0] b, input bit typed, input string run_text);
      directed_rows.push_back('{new_setting: 0, setting: SET_PLAIN, in_byte: b, typed: typed,
                                run_text: run_text});
   endtask

   // Result side: pop after a random gap, or after one long hold-off when
   // asked; check each accepted word against the oldest expectation.
   initial begin : word_sink
      int       gap;
      word_type exp_word;
      wait (reset_done);
      forever begin
         if (hold_request) begin
            gap = HOLD_CYCLES;
            hold_request = 0;
         end else if (no_idle) begin
            gap = 0;
         end else begin
            gap = $urandom_range(0, MAX_GAP);
         end
         if (gap != 0) begin
            pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         pop <= 1'b1;
         do @(posedge clock); while (empty);
         if (expected_words.size() == 0) begin
            report_mismatch($sformatf("unexpected word out_byte=%h last=%b",
                                      rsp_out_byte, rsp_last_of_run));
         end else begin
            exp_word = expected_words.pop_front();
            if (rsp_out_byte !== exp_word.out_byte)
               report_mismatch($sformatf("out_byte got %h expected %h",
                                         rsp_out_byte, exp_word.out_byte));
            if (rsp_last_of_run !== exp_word.last_of_run)
               report_mismatch($sformatf("last_of_run got %b expected %b",
                                         rsp_last_of_run, exp_word.last_of_run));
         end
         words_checked++;
      end
   end

   initial begin : byte_source
      logic [5:0] s;

      filter_cfg       = '0;
      in_line          = 1'b0;
      after_empty_line = 1'b0;
      line_no          = 20'd1;

      // Directed table. Typed runs are read straight off the filter rules;
      // the others fall back on the predictor.
      // After reset: every register clear, bytes pass through untouched
      add_byte_row("A",   1, "A");
      add_byte_row(8'h00, 0, "");
      add_byte_row(8'hFF, 0, "");
      add_byte_row(CHAR_NEWLINE, 1, "\n");
      // Numbering, line ends and escapes; the high tab stays M-^I with tabs off
      add_setting_row(SET_NUMBER_ESCAPE_ENDS);
      add_byte_row(8'h89, 1, "     1\tM-^I");
      add_byte_row(CHAR_DEL, 1, "^?");
      add_byte_row(8'hFF, 1, "M-^?");
      add_byte_row(8'h00, 1, "^@");
      add_byte_row(CHAR_TAB, 1, "\t");
      add_byte_row(8'h1F, 1, "^_");
      add_byte_row("z", 1, "z");
      add_byte_row(CHAR_NEWLINE, 1, "$\n");
      add_byte_row(CHAR_NEWLINE, 1, "     2\t$\n");
      add_byte_row(8'h80, 1, "     3\tM-^@");
      // Everything on: empty line unnumbered, the repeat squeezed to nothing
      add_setting_row(SET_ALL);
      add_byte_row(CHAR_NEWLINE, 1, "$\n");
      add_byte_row(CHAR_NEWLINE, 1, "$\n");
      add_byte_row(CHAR_NEWLINE, 1, "");
      add_byte_row(CHAR_TAB, 1, "     4\t^I");
      add_byte_row(CHAR_NEWLINE, 1, "$\n");
      // Nonblank-only without numbering and tabs without escapes: no effect
      add_setting_row(SET_ORPHAN_MODES);
      add_byte_row(CHAR_TAB, 1, "\t");
      add_byte_row(8'h89, 0, "");
      add_byte_row("~", 1, "~");
      add_byte_row(CHAR_NEWLINE, 1, "\n");

      // Hold reset, then release it once; it is never raised again
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      reset_done = 1;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].new_setting) begin
            apply_setting(directed_rows[i].setting);
         end else begin
            send_byte(directed_rows[i].in_byte, directed_rows[i].typed,
                      directed_rows[i].run_text);
         end
      end

      // Random text: both extremes first, then random settings. One phase
      // runs without gaps; another rushes bytes while the receiver holds off.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0:       s = SET_ALL;
            1:       s = SET_PLAIN;
            default: s = 6'($urandom_range(0, 63));
         endcase
         apply_setting(s);
         no_idle = (phase == 1);
         rush    = (phase == 3);
         if (phase == 3) hold_request = 1;
         for (int n = 0; n < PHASE_BYTES; n++) send_byte(random_text_byte(), 0, "");
      end
      no_idle = 0;
      rush    = 0;
      push <= 1'b0;

      // Drain, then give any stray word time to show up
      while (expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_words.size() != 0)
         report_mismatch($sformatf("%0d expected words never arrived", expected_words.size()));

      $display("covered %0d bytes under %0d register settings, %0d words checked",
               bytes_sent, settings_used, words_checked);
      $display("input stalled on %0d cycles, last line number issued %0d, %0d mismatches",
               input_stalls, line_no - 20'd1, mismatches);
      if (mismatches == 0) begin
         $display("tb_text_line_number_escape_filter_unit passed");
      end else begin
         $display("tb_text_line_number_escape_filter_unit failed");
      end
      $finish;
   end

endmodule
